@@ rtl/assert_macros.svh @@
// Assertion macros used by the heap top level.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ffh_pkg.sv @@
// Package for the first-fit heap: sizes, field widths, action and status codes.
// No dependencies.
`default_nettype none
package ffh_pkg;
	localparam int HEAP_WORDS = 128;
	localparam int MAX_ARRAYS = 16;
	localparam int WORD_BITS  = 32;
	localparam int AW = $clog2(HEAP_WORDS);
	localparam int SW = $clog2(MAX_ARRAYS);
	localparam int LW = 8;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 40;

	typedef enum logic [1:0] {
		ACT_CREATE = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_WRITE  = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_FULL       = 3'd1,
		STS_NO_HANDLE  = 3'd2,
		STS_ZERO       = 3'd3,
		STS_BAD_HANDLE = 3'd4,
		STS_BAD_POS    = 3'd5
	} status_t;
endpackage
`default_nettype wire

@@ rtl/first_fit_heap_with_compaction.sv @@
// First-fit heap allocator with compaction, top level.
// Depends on ffh_pkg and assert_macros.svh.
//
// Input stream s_*: s_tuser = action, s_tdata = length, handle, position,
// write_value. One item is worked on at a time; s_tready is high only
// while the block is idle. Output stream m_*: one result transfer per item,
// held in an output register until taken; a stalled receiver holds the
// next result back and keeps s_tready low only once that result is done.
// Result path after the accepting edge: zero size and no free handle go
// straight to S_DONE; delete, write, bad handle and bad position pass
// S_CHK first; read passes S_CHK and S_RD. The next transfer can be taken in
// the cycle after the result is loaded. Create scans the 16 slots once per
// array passed in address order plus once to place (up to 16 passes), then
// loads the result. A compaction adds a pass per array plus a closing
// pass and reads (S_CRD) then writes (S_CWR) each word moved, then the fit
// is retried. Scans use one shared slot comparator, a slot at a time.
// Reset (arst_n low) clears all slots and marks every heap word as zero,
// at once; the block is ready as soon as reset is released.
`default_nettype none
module first_fit_heap_with_compaction (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [7:0] length, [11:8] handle, [19:12] position, [51:20] write_value
	input  wire logic [ffh_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] action
	input  wire logic [1:0]                    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [2:0] status, [6:3] new_handle, [38:7] read_value, [39] compacted
	output logic [ffh_pkg::M_TDATA_W-1:0]      m_tdata
);
	import ffh_pkg::*;
`include "assert_macros.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_RD, S_FSCAN, S_FEVAL, S_CSCAN, S_CEVAL, S_CRD, S_CWR, S_DONE
	} state_t;

	localparam logic [LW-1:0] HEAP_END = LW'(HEAP_WORDS);

	state_t state_q;
	logic [WORD_BITS-1:0] mem_q [HEAP_WORDS];
	logic [HEAP_WORDS-1:0] mvld_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic rvld_q;

	logic [MAX_ARRAYS-1:0] slot_use_q;
	logic [AW-1:0] slot_base_q [MAX_ARRAYS];
	logic [LW-1:0] slot_len_q [MAX_ARRAYS];

	action_t act_q;
	logic [LW-1:0] len_q, pos_q, cur_q, j_q, best_len_q;
	logic [WORD_BITS-1:0] val_q, res_value_q;
	logic [SW-1:0] idx_q, best_idx_q, res_handle_q;
	logic [AW-1:0] best_base_q;
	logic comp_q, found_q;
	status_t res_status_q;
	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic su, hit, full, mem_we, wvld;
	logic [AW-1:0] sb, waddr, raddr;
	logic [LW-1:0] sl, addr, gap, cw_sum, cr_sum;
	logic [SW-1:0] freeslot;
	logic [WORD_BITS-1:0] wdata;

	assign su  = slot_use_q[idx_q];
	assign sb  = slot_base_q[idx_q];
	assign sl  = slot_len_q[idx_q];
	assign hit = su && ({1'b0, sb} >= cur_q) && (!found_q || sb < best_base_q);
	assign addr = {1'b0, sb} + pos_q - LW'(1);
	assign gap  = {1'b0, best_base_q} - cur_q;
	assign cw_sum = cur_q + j_q;
	assign cr_sum = {1'b0, best_base_q} + j_q;
	assign full = &slot_use_q;

	always_comb begin
		freeslot = '0;
		for (int i = MAX_ARRAYS - 1; i >= 0; i--) begin
			if (!slot_use_q[i]) freeslot = SW'(i);
		end
	end

	always_comb begin
		mem_we = 1'b0;
		if (state_q == S_CWR) mem_we = 1'b1;
		if (state_q == S_CHK && act_q == ACT_WRITE && su && pos_q != '0 && pos_q <= sl)
			mem_we = 1'b1;
		waddr = (state_q == S_CWR) ? cw_sum[AW-1:0] : addr[AW-1:0];
		wdata = (state_q == S_CWR) ? rdata_q : val_q;
		wvld  = (state_q == S_CWR) ? rvld_q : 1'b1;
		raddr = (state_q == S_CRD) ? cr_sum[AW-1:0] : addr[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvld_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (mem_we) mvld_q[waddr] <= wvld;
			rvld_q <= mvld_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			slot_use_q <= '0;
			for (int i = 0; i < MAX_ARRAYS; i++) begin
				slot_base_q[i] <= '0;
				slot_len_q[i]  <= '0;
			end
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q        <= action_t'(s_tuser);
						len_q        <= s_tdata[7:0];
						idx_q        <= s_tdata[11:8];
						pos_q        <= s_tdata[19:12];
						val_q        <= s_tdata[51:20];
						res_status_q <= STS_OK;
						res_handle_q <= '0;
						res_value_q  <= '0;
						comp_q       <= 1'b0;
						cur_q        <= '0;
						found_q      <= 1'b0;
						if (action_t'(s_tuser) != ACT_CREATE) begin
							state_q <= S_CHK;
						end else if (s_tdata[7:0] == '0) begin
							res_status_q <= STS_ZERO;
							state_q      <= S_DONE;
						end else if (full) begin
							res_status_q <= STS_NO_HANDLE;
							state_q      <= S_DONE;
						end else begin
							idx_q   <= '0;
							state_q <= S_FSCAN;
						end
					end
				end
				S_CHK: begin
					state_q <= S_DONE;
					if (!su) begin
						res_status_q <= STS_BAD_HANDLE;
					end else if (act_q == ACT_DELETE) begin
						slot_use_q[idx_q]  <= 1'b0;
						slot_base_q[idx_q] <= '0;
						slot_len_q[idx_q]  <= '0;
					end else if (pos_q == '0 || pos_q > sl) begin
						res_status_q <= STS_BAD_POS;
					end else if (act_q == ACT_READ) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					res_value_q <= rvld_q ? rdata_q : '0;
					state_q     <= S_DONE;
				end
				S_FSCAN, S_CSCAN: begin
					if (hit) begin
						found_q     <= 1'b1;
						best_base_q <= sb;
						best_idx_q  <= idx_q;
						best_len_q  <= sl;
					end
					idx_q <= idx_q + SW'(1);
					if (idx_q == SW'(MAX_ARRAYS - 1))
						state_q <= (state_q == S_FSCAN) ? S_FEVAL : S_CEVAL;
				end
				S_FEVAL: begin
					found_q <= 1'b0;
					idx_q   <= '0;
					if (found_q && gap < len_q) begin
						cur_q   <= {1'b0, best_base_q} + best_len_q;
						state_q <= S_FSCAN;
					end else if (found_q || (HEAP_END - cur_q >= len_q)) begin
						slot_use_q[freeslot]  <= 1'b1;
						slot_base_q[freeslot] <= cur_q[AW-1:0];
						slot_len_q[freeslot]  <= len_q;
						res_handle_q          <= freeslot;
						state_q               <= S_DONE;
					end else if (!comp_q) begin
						comp_q  <= 1'b1;
						cur_q   <= '0;
						state_q <= S_CSCAN;
					end else begin
						res_status_q <= STS_FULL;
						state_q      <= S_DONE;
					end
				end
				S_CEVAL: begin
					j_q <= '0;
					if (found_q) begin
						state_q <= S_CRD;
					end else begin
						cur_q   <= '0;
						idx_q   <= '0;
						state_q <= S_FSCAN;
					end
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					j_q <= j_q + LW'(1);
					if (j_q + LW'(1) == best_len_q) begin
						slot_base_q[best_idx_q] <= cur_q[AW-1:0];
						cur_q   <= cur_q + best_len_q;
						found_q <= 1'b0;
						idx_q   <= '0;
						state_q <= S_CSCAN;
					end else begin
						state_q <= S_CRD;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {comp_q, res_value_q, res_handle_q, res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_IMPLIES(a_compact_status, clk, arst_n, m_tvalid && m_tdata[39],
		m_tdata[2:0] == STS_OK || m_tdata[2:0] == STS_FULL)
	`ASSERT_IMPLIES(a_read_ok, clk, arst_n, m_tvalid && m_tdata[38:7] != '0,
		m_tdata[2:0] == STS_OK)
	`ASSERT_IMPLIES(a_handle_ok, clk, arst_n, m_tvalid && m_tdata[6:3] != '0,
		m_tdata[2:0] == STS_OK)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
endmodule
`default_nettype wire
